// ----- rtl/core/ptv_pkg.sv -----
// ----------------------------------------------------------------------------
// ptv_pkg
// Shared constants and types for the pixel temporal hit vote unit.
// ----------------------------------------------------------------------------
package ptv_pkg;

   // sizing of the per-pixel history store
   localparam int MAX_WINDOW = 16;
   localparam int MAX_PIXELS = 131072;

   localparam int HIST_W  = MAX_WINDOW;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W   = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int POS_W   = $clog2(MAX_PIXELS);
   localparam int FRAME_W = POS_W + 1;
   localparam int WORD_W  = HIST_W + CNT_W;

   // fixed field widths
   localparam int DIFF_W     = 13;
   localparam int TOTAL_W    = 5;
   localparam int WIN_REG_W  = 5;
   localparam int MIN_REG_W  = 5;
   localparam int FRM_REG_W  = 18;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // register map
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_HITS  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN = 2'd3;

   // reset values
   localparam logic signed [DIFF_W-1:0] RST_THRESHOLD = 13'sd80;
   localparam logic [WIN_REG_W-1:0]     RST_WINDOW    = 5'd5;
   localparam logic [MIN_REG_W-1:0]     RST_MIN_HITS  = 5'd3;
   localparam logic [FRM_REG_W-1:0]     RST_FRAME_LEN = 18'd81920;

   // effective (clamped) configuration seen by the datapath
   typedef struct packed {
      logic                     clear;
      logic signed [DIFF_W-1:0] threshold;
      logic [CNT_W-1:0]         win_n;
      logic [CNT_W-1:0]         min_m;
      logic [FRAME_W-1:0]       frame_len;
   } cfg_type;

endpackage

// ----- rtl/core/ptv_csr.sv -----
// ----------------------------------------------------------------------------
// ptv_csr
// APB register file; hands clamped settings and a clear strobe to the datapath.
// ----------------------------------------------------------------------------
module ptv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptv_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ptv_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ptv_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output ptv_pkg::cfg_type                    cfg
);

   localparam int CntW   = ptv_pkg::CNT_W;
   localparam int FrameW = ptv_pkg::FRAME_W;
   localparam int DataW  = ptv_pkg::CSR_DATA_W;
   localparam int DiffW  = ptv_pkg::DIFF_W;

   logic signed [ptv_pkg::DIFF_W-1:0] thr_ff, thr_in;
   logic [ptv_pkg::WIN_REG_W-1:0]     win_ff, win_in;
   logic [ptv_pkg::MIN_REG_W-1:0]     min_ff, min_in;
   logic [ptv_pkg::FRM_REG_W-1:0]     frame_ff, frame_in;
   logic                              wr_en;
   logic [ptv_pkg::REG_IDX_W-1:0]     reg_idx;
   logic [CntW-1:0]                   win_eff;
   logic [CntW-1:0]                   min_eff;
   logic [FrameW-1:0]                 frame_eff;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[ptv_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      thr_in   = thr_ff;
      win_in   = win_ff;
      min_in   = min_ff;
      frame_in = frame_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ptv_pkg::REG_THRESHOLD: thr_in   = csr_pwdata[ptv_pkg::DIFF_W-1:0];
            ptv_pkg::REG_WINDOW:    win_in   = csr_pwdata[ptv_pkg::WIN_REG_W-1:0];
            ptv_pkg::REG_MIN_HITS:  min_in   = csr_pwdata[ptv_pkg::MIN_REG_W-1:0];
            ptv_pkg::REG_FRAME_LEN: frame_in = csr_pwdata[ptv_pkg::FRM_REG_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= ptv_pkg::RST_THRESHOLD;
         win_ff   <= ptv_pkg::RST_WINDOW;
         min_ff   <= ptv_pkg::RST_MIN_HITS;
         frame_ff <= ptv_pkg::RST_FRAME_LEN;
      end else begin
         thr_ff   <= thr_in;
         win_ff   <= win_in;
         min_ff   <= min_in;
         frame_ff <= frame_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         ptv_pkg::REG_THRESHOLD:
            csr_prdata = {{(DataW-DiffW){thr_ff[DiffW-1]}}, thr_ff};
         ptv_pkg::REG_WINDOW:    csr_prdata = DataW'(win_ff);
         ptv_pkg::REG_MIN_HITS:  csr_prdata = DataW'(min_ff);
         ptv_pkg::REG_FRAME_LEN: csr_prdata = DataW'(frame_ff);
      endcase
   end

   // clamp window, minimum hits and frame length into their usable ranges
   always_comb begin
      if (win_ff == '0) begin
         win_eff = CntW'(1);
      end else if (32'(win_ff) > ptv_pkg::MAX_WINDOW) begin
         win_eff = CntW'(ptv_pkg::MAX_WINDOW);
      end else begin
         win_eff = CntW'(win_ff);
      end

      if (min_ff == '0) begin
         min_eff = CntW'(1);
      end else if (32'(min_ff) > 32'(win_eff)) begin
         min_eff = win_eff;
      end else begin
         min_eff = CntW'(min_ff);
      end

      if (frame_ff == '0) begin
         frame_eff = FrameW'(1);
      end else if (32'(frame_ff) > ptv_pkg::MAX_PIXELS) begin
         frame_eff = FrameW'(ptv_pkg::MAX_PIXELS);
      end else begin
         frame_eff = FrameW'(frame_ff);
      end
   end

   assign cfg.clear     = wr_en;
   assign cfg.threshold = thr_ff;
   assign cfg.win_n     = win_eff;
   assign cfg.min_m     = min_eff;
   assign cfg.frame_len = frame_eff;

endmodule

// ----- rtl/core/ptv_hist_ram.sv -----
// ----------------------------------------------------------------------------
// ptv_hist_ram
// Per-pixel history and count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptv_hist_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ptv_pkg::POS_W-1:0]     rd_addr,
   output logic [ptv_pkg::WORD_W-1:0]    rd_data,
   input  logic                          wr_en,
   input  logic [ptv_pkg::POS_W-1:0]     wr_addr,
   input  logic [ptv_pkg::WORD_W-1:0]    wr_data
);

   logic [ptv_pkg::WORD_W-1:0] store_mem [ptv_pkg::MAX_PIXELS];
   logic [ptv_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pixel_temporal_hit_vote_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_temporal_hit_vote_unit
// Per-pixel M-of-N temporal persistence filter over a raster difference stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_pixel_diff
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_frame_hit, rsp_hit_total,
//          |           |                        | rsp_confirmed, rsp_frame_end
//  csr     | in/out    | APB psel/penable       | paddr, pwdata, prdata
//
// One pixel per clock while rsp_stall is low; a result passes the work stage
// and then the output register. The history store is read at acceptance and
// written back as the pixel leaves the work stage; a pixel revisited by the next
// transaction takes the write-back data by bypass.
// Reset or any register write empties the history: the first frame after it
// reads every entry as zero, so no clearing pass is needed.
// rsp_stall holds the output register and backs up into req_stall.
// ----------------------------------------------------------------------------
module pixel_temporal_hit_vote_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ptv_pkg::DIFF_W-1:0]      req_pixel_diff,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_frame_hit,
   output logic [ptv_pkg::TOTAL_W-1:0]            rsp_hit_total,
   output logic                                   rsp_confirmed,
   output logic                                   rsp_frame_end,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ptv_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [ptv_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [ptv_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam int CntW   = ptv_pkg::CNT_W;
   localparam int HistW  = ptv_pkg::HIST_W;
   localparam int IdxW   = ptv_pkg::IDX_W;
   localparam int PosW   = ptv_pkg::POS_W;
   localparam int FrameW = ptv_pkg::FRAME_W;
   localparam int WordW  = ptv_pkg::WORD_W;
   localparam int TotalW = ptv_pkg::TOTAL_W;

   ptv_pkg::cfg_type cfg;

   logic accept;
   logic a_adv;

   // position tracking
   logic [PosW-1:0]   pos_cnt_ff, pos_cnt_in;
   logic              fresh_ff, fresh_in;
   logic [FrameW-1:0] pos_next;
   logic              pos_last;

   // work stage
   logic                              a_valid_ff, a_valid_in;
   logic signed [ptv_pkg::DIFF_W-1:0] a_diff_ff;
   logic [PosW-1:0]                   a_pos_ff;
   logic                              a_last_ff;
   logic                              a_zero_ff;
   logic                              a_fwd_ff;
   logic [WordW-1:0]                  a_fwd_word_ff;
   logic [WordW-1:0]                  rd_word;
   logic [WordW-1:0]                  old_word;
   logic [WordW-1:0]                  new_word;
   logic [HistW-1:0]                  old_hist;
   logic [CntW-1:0]                   old_cnt;
   logic [HistW-1:0]                  hist_mask;
   logic [HistW-1:0]                  new_hist;
   logic [CntW-1:0]                   new_cnt;
   logic [CntW-1:0]                   total;
   logic                              hit;
   logic                              oldest;
   logic                              conf;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic [TotalW-1:0] rsp_total_ff;
   logic              rsp_conf_ff;
   logic              rsp_end_ff;

   ptv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ptv_hist_ram u_hist_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos_cnt_ff),
      .rd_data (rd_word),
      .wr_en   (a_adv),
      .wr_addr (a_pos_ff),
      .wr_data (new_word)
   );

   // handshake
   assign a_adv     = a_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = a_valid_ff & ~a_adv;
   assign accept    = req_valid & ~req_stall;

   // raster position
   assign pos_next = FrameW'(pos_cnt_ff) + FrameW'(1);
   assign pos_last = (pos_next >= cfg.frame_len);

   always_comb begin
      pos_cnt_in = pos_cnt_ff;
      fresh_in   = fresh_ff;
      if (cfg.clear) begin
         pos_cnt_in = '0;
         fresh_in   = 1'b1;
      end else if (accept) begin
         pos_cnt_in = pos_last ? '0 : pos_next[PosW-1:0];
         if (pos_last) begin
            fresh_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_cnt_ff <= '0;
         fresh_ff   <= 1'b1;
      end else begin
         pos_cnt_ff <= pos_cnt_in;
         fresh_ff   <= fresh_in;
      end
   end

   // work stage registers
   assign a_valid_in = accept | (a_valid_ff & ~a_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_diff_ff     <= req_pixel_diff;
         a_pos_ff      <= pos_cnt_ff;
         a_last_ff     <= pos_last;
         a_zero_ff     <= fresh_ff;
         // same pixel written back at this edge: the RAM read is stale
         a_fwd_ff      <= a_adv & (a_pos_ff == pos_cnt_ff);
         a_fwd_word_ff <= new_word;
      end
   end

   // vote update
   always_comb begin
      if (a_fwd_ff) begin
         old_word = a_fwd_word_ff;
      end else if (a_zero_ff) begin
         old_word = '0;
      end else begin
         old_word = rd_word;
      end
      old_hist = old_word[HistW-1:0];
      old_cnt  = old_word[HistW +: CntW];

      hit = (a_diff_ff > cfg.threshold);

      for (int i = 0; i < HistW; i++) begin
         hist_mask[i] = (CntW'(i) < cfg.win_n);
      end
      oldest   = old_hist[IdxW'(cfg.win_n - CntW'(1))];
      new_hist = {old_hist[HistW-2:0], hit} & hist_mask;
      new_cnt  = old_cnt - CntW'(oldest) + CntW'(hit);

      if (cfg.win_n == CntW'(1)) begin
         new_word = '0;
         total    = CntW'(hit);
         conf     = hit;
      end else begin
         new_word = {new_cnt, new_hist};
         total    = new_cnt;
         conf     = (new_cnt >= cfg.min_m);
      end
   end

   // output register
   assign rsp_valid_in = a_adv | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         rsp_hit_ff   <= hit;
         rsp_total_ff <= TotalW'(total);
         rsp_conf_ff  <= conf;
         rsp_end_ff   <= a_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_hit = rsp_hit_ff;
   assign rsp_hit_total = rsp_total_ff;
   assign rsp_confirmed = rsp_conf_ff;
   assign rsp_frame_end = rsp_end_ff;

   // checks
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("work stage overran a stalled output register");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      FrameW'(pos_cnt_ff) < cfg.frame_len)
      else $error("raster position beyond frame length");

   a_conf_has_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_confirmed |-> rsp_frame_hit || (rsp_hit_total != '0))
      else $error("confirmed transaction without any hit");

   a_fwd_only_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(a_fwd_ff) |-> $past(a_adv))
      else $error("bypass taken without a write-back");

endmodule

// ----- tb/tb_pixel_temporal_hit_vote_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_temporal_hit_vote_unit
// Self-checking bench for the per-pixel M-of-N hit vote unit. A directed table
// covers the field extremes, the clamped window, minimum and frame settings
// and the single-frame window. A random part then reprograms the unit between
// bursts of pixels with controlled hit density, so that long per-pixel runs
// of hits build up. Each result is compared with its table row or an in-bench vote predictor.
// ----------------------------------------------------------------------------
module tb_pixel_temporal_hit_vote_unit;

   localparam int TotalW = ptv_pkg::TOTAL_W;

   typedef struct packed {
      logic                          frame_hit;
      logic [ptv_pkg::TOTAL_W-1:0]   hit_total;
      logic                          confirmed;
      logic                          frame_end;
   } vote_type;

   typedef struct {
      bit       typed;
      vote_type want;
   } pending_type;

   typedef struct {
      bit                                 is_write;
      logic [ptv_pkg::REG_IDX_W-1:0]      reg_idx;
      int                                 value;
      logic signed [ptv_pkg::DIFF_W-1:0]  diff;
      bit                                 typed;
      vote_type                           want;
   } row_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [ptv_pkg::DIFF_W-1:0]     req_pixel_diff = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_frame_hit;
   logic [ptv_pkg::TOTAL_W-1:0]           rsp_hit_total;
   logic                                  rsp_confirmed;
   logic                                  rsp_frame_end;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [ptv_pkg::CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [ptv_pkg::CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [ptv_pkg::CSR_DATA_W-1:0]        csr_prdata;
   logic                                  csr_pready;

   // predictor copy of the configuration and per-pixel vote store
   logic signed [ptv_pkg::DIFF_W-1:0]     cfg_thresh = ptv_pkg::RST_THRESHOLD;
   logic [ptv_pkg::WIN_REG_W-1:0]         cfg_window = ptv_pkg::RST_WINDOW;
   logic [ptv_pkg::MIN_REG_W-1:0]         cfg_min    = ptv_pkg::RST_MIN_HITS;
   logic [ptv_pkg::FRM_REG_W-1:0]         cfg_frame  = ptv_pkg::RST_FRAME_LEN;
   logic [ptv_pkg::HIST_W-1:0]            pixel_history [int];
   int                                    pixel_votes [int];
   int                                    vote_pos = 0;

   vote_type                              expected_votes [$];
   pending_type                           pending_checks [$];
   row_type                               directed_rows [$];
   int                                    error_count = 0;
   bit                                    no_idle = 1'b0;

   pixel_temporal_hit_vote_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_diff (req_pixel_diff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_hit  (rsp_frame_hit),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_confirmed  (rsp_confirmed),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #4 clock = ~clock;

   // one pixel through the M-of-N vote, advancing the predictor state
   function automatic vote_type predict_vote(input logic signed [ptv_pkg::DIFF_W-1:0] diff);
      int          n;
      int          m;
      int          fp;
      int          pos;
      int          c;
      logic [31:0] h;
      logic        hit;
      vote_type    v;
      n  = int'(cfg_window);
      m  = int'(cfg_min);
      fp = int'(cfg_frame);
      if (n < 1) n = 1;
      if (n > ptv_pkg::MAX_WINDOW) n = ptv_pkg::MAX_WINDOW;
      if (m < 1) m = 1;
      if (m > n) m = n;
      if (fp < 1) fp = 1;
      if (fp > ptv_pkg::MAX_PIXELS) fp = ptv_pkg::MAX_PIXELS;
      pos = (vote_pos >= fp) ? 0 : vote_pos;
      hit = (diff > cfg_thresh);
      if (n == 1) begin
         pixel_history[pos] = '0;
         pixel_votes[pos]   = 0;
         v.hit_total = TotalW'(hit);
         v.confirmed = hit;
      end else begin
         h = pixel_history.exists(pos) ? 32'(pixel_history[pos]) : 32'd0;
         c = pixel_votes.exists(pos) ? pixel_votes[pos] : 0;
         c = c - int'(h[n-1]) + int'(hit);
         h = ((h << 1) | 32'(hit)) & ((32'd1 << n) - 32'd1);
         pixel_history[pos] = h[ptv_pkg::HIST_W-1:0];
         pixel_votes[pos]   = c;
         v.hit_total = c[TotalW-1:0];
         v.confirmed = (c >= m);
      end
      v.frame_hit = hit;
      v.frame_end = (pos + 1 >= fp);
      vote_pos = v.frame_end ? 0 : pos + 1;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic row_pixel(input int diff, input bit typed, input bit hit, input int total,
                            input bit conf, input bit last);
      row_type row;
      row.is_write = 1'b0;
      row.reg_idx  = ptv_pkg::REG_THRESHOLD;
      row.value    = 0;
      row.diff     = diff[ptv_pkg::DIFF_W-1:0];
      row.typed    = typed;
      row.want     = {hit, total[TotalW-1:0], conf, last};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic row_write(input logic [ptv_pkg::REG_IDX_W-1:0] idx, input int value);
      row_type row;
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.value    = value;
      row.diff     = '0;
      row.typed    = 1'b0;
      row.want     = '0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // register write, only once the unit has drained
   task automatic write_reg(input logic [ptv_pkg::REG_IDX_W-1:0] idx, input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_votes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      unique case (idx)
         ptv_pkg::REG_THRESHOLD: cfg_thresh = value[ptv_pkg::DIFF_W-1:0];
         ptv_pkg::REG_WINDOW:    cfg_window = value[ptv_pkg::WIN_REG_W-1:0];
         ptv_pkg::REG_MIN_HITS:  cfg_min    = value[ptv_pkg::MIN_REG_W-1:0];
         ptv_pkg::REG_FRAME_LEN: cfg_frame  = value[ptv_pkg::FRM_REG_W-1:0];
      endcase
      // any register write empties the vote store
      pixel_history.delete();
      pixel_votes.delete();
      vote_pos = 0;
   endtask

   // returns at the edge where the pixel transaction is taken
   task automatic send_pixel(input logic signed [ptv_pkg::DIFF_W-1:0] diff, input bit typed,
                             input vote_type want);
      pending_type note;
      note.typed = typed;
      note.want  = want;
      pending_checks.insert(pending_checks.size(), note);
      while (!no_idle && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_diff <= diff;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !no_idle && ($urandom_range(0, 99) < 23);
   end

   always @(posedge clock) begin : monitor
      vote_type    got;
      vote_type    want;
      pending_type note;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_vote(req_pixel_diff);
            if (pending_checks.size() != 0) begin
               note = pending_checks.pop_front();
               if (note.typed) want = note.want;
            end
            expected_votes.insert(expected_votes.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_frame_hit, rsp_hit_total, rsp_confirmed, rsp_frame_end};
            if (expected_votes.size() == 0) begin
               report_mismatch("result with nothing pending", got, 0);
            end else begin
               want = expected_votes.pop_front();
               if (got.frame_hit !== want.frame_hit)
                  report_mismatch("frame_hit", got.frame_hit, want.frame_hit);
               if (got.hit_total !== want.hit_total)
                  report_mismatch("hit_total", got.hit_total, want.hit_total);
               if (got.confirmed !== want.confirmed)
                  report_mismatch("confirmed", got.confirmed, want.confirmed);
               if (got.frame_end !== want.frame_end)
                  report_mismatch("frame_end", got.frame_end, want.frame_end);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int       i;
      int       k;
      int       t;
      int       d;
      int       sent;
      int       phase;
      int       count;
      int       density;
      int       value;
      vote_type none;
      none = '0;

      // reset config: threshold 80, N 5, M 3, large frame
      row_pixel(81, 1, 1, 1, 0, 0);
      row_pixel(80, 1, 0, 0, 0, 0);
      row_pixel(-4096, 1, 0, 0, 0, 0);
      row_pixel(4095, 1, 1, 1, 0, 0);
      row_pixel(-4080, 1, 0, 0, 0, 0);
      row_pixel(4080, 1, 1, 1, 0, 0);
      // two-pixel frame, two-frame window, zero minimum acts as one
      row_write(ptv_pkg::REG_FRAME_LEN, 2);
      row_write(ptv_pkg::REG_WINDOW, 2);
      row_write(ptv_pkg::REG_MIN_HITS, 0);
      row_write(ptv_pkg::REG_THRESHOLD, -4096);
      row_pixel(-4095, 1, 1, 1, 1, 0);
      row_pixel(-4096, 1, 0, 0, 0, 1);
      row_pixel(0, 0, 0, 0, 0, 0);
      row_pixel(5, 0, 0, 0, 0, 0);
      row_pixel(0, 0, 0, 0, 0, 0);
      // single-frame window with the top threshold: nothing can hit
      row_write(ptv_pkg::REG_WINDOW, 1);
      row_write(ptv_pkg::REG_THRESHOLD, 4095);
      row_pixel(4095, 1, 0, 0, 0, 0);
      row_pixel(-1, 1, 0, 0, 0, 1);
      // zero window acts as one: pass-through
      row_write(ptv_pkg::REG_THRESHOLD, 0);
      row_write(ptv_pkg::REG_WINDOW, 0);
      row_pixel(1, 1, 1, 1, 1, 0);
      row_pixel(0, 1, 0, 0, 0, 1);
      // oversized window and minimum, zero frame acts as one pixel
      row_write(ptv_pkg::REG_WINDOW, 31);
      row_write(ptv_pkg::REG_MIN_HITS, 31);
      row_write(ptv_pkg::REG_FRAME_LEN, 0);
      row_pixel(4095, 0, 0, 0, 0, 0);
      row_pixel(4095, 0, 0, 0, 0, 0);
      row_pixel(4095, 0, 0, 0, 0, 0);
      // oversized frame clamps to the store size
      row_write(ptv_pkg::REG_FRAME_LEN, 262143);
      row_write(ptv_pkg::REG_WINDOW, 16);
      row_write(ptv_pkg::REG_MIN_HITS, 16);
      row_pixel(-2048, 1, 0, 0, 0, 0);
      row_pixel(2047, 1, 1, 1, 0, 0);
      row_write(ptv_pkg::REG_FRAME_LEN, ptv_pkg::MAX_PIXELS);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_write)
            write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
         else
            send_pixel(directed_rows[i].diff, directed_rows[i].typed, directed_rows[i].want);
      end

      sent  = 0;
      phase = 0;
      while (sent < 600) begin
         if ($urandom_range(0, 99) < 60) begin
            k = $urandom_range(0, 99);
            if (k < 70)      value = $urandom_range(1, 8);
            else if (k < 90) value = $urandom_range(9, 200);
            else begin
               case ($urandom_range(0, 3))
                  0:       value = 0;
                  1:       value = ptv_pkg::MAX_PIXELS;
                  2:       value = 262143;
                  default: value = $urandom_range(ptv_pkg::MAX_PIXELS + 1, 262143);
               endcase
            end
            write_reg(ptv_pkg::REG_FRAME_LEN, value);
         end
         if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 99) < 15) begin
               case ($urandom_range(0, 3))
                  0:       value = 0;
                  1:       value = 1;
                  2:       value = 31;
                  default: value = $urandom_range(17, 30);
               endcase
            end else begin
               value = $urandom_range(2, ptv_pkg::MAX_WINDOW);
            end
            write_reg(ptv_pkg::REG_WINDOW, value);
         end
         if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 99) < 25) value = $urandom_range(0, 31);
            else                            value = $urandom_range(1, ptv_pkg::MAX_WINDOW);
            write_reg(ptv_pkg::REG_MIN_HITS, value);
         end
         if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 99) < 20) value = int'($urandom_range(0, 8191)) - 4096;
            else                            value = int'($urandom_range(0, 400)) - 200;
            write_reg(ptv_pkg::REG_THRESHOLD, value);
         end

         // one burst runs with both sides streaming flat out
         no_idle = (phase == 4);
         count   = no_idle ? 150 : $urandom_range(20, 80);
         case ($urandom_range(0, 3))
            0:       density = 5;
            1:       density = 50;
            2:       density = 85;
            default: density = 100;
         endcase
         t = cfg_thresh;
         for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 10 || (t >= 4095 && density > 50))
               d = int'($urandom_range(0, 8191)) - 4096;
            else if ($urandom_range(0, 99) < density && t < 4095)
               d = t + 1 + int'($urandom_range(0, 4094 - t));
            else
               d = -4096 + int'($urandom_range(0, t + 4096));
            send_pixel(d[ptv_pkg::DIFF_W-1:0], 1'b0, none);
            sent++;
         end
         no_idle = 1'b0;
         phase++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_votes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
